>>> hw/rtl/text_console_writer_core_macros.svh
// assertion macros shared by the console checker
// no dependencies; included by the checker file
`ifndef TEXT_CONSOLE_WRITER_CORE_MACROS_SVH
`define TEXT_CONSOLE_WRITER_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define TCW_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("console check failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define TCW_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("console check failed: next-cycle implication");

`endif

>>> hw/rtl/tcw_pkg.sv
// shared types and constants of the text console writer
// no dependencies; used by every console module
package tcw_pkg;

   // control characters
   localparam logic [7:0]  CH_CR       = 8'h0d;
   localparam logic [7:0]  CH_LF       = 8'h0a;

   // reset values of registers and screen cells
   localparam logic [7:0]  RESET_ATTR  = 8'h0c;
   localparam logic [15:0] RESET_BLANK = 16'h0720;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // configuration register map
   localparam int CSR_DATA_W = 16;
   typedef enum logic [0:0] {
      CSR_TEXT_ATTR  = 1'b0,
      CSR_BLANK_CELL = 1'b1
   } tcw_csr_index_type;

   // memory work that one command asks of the back end
   typedef struct packed {
      logic rd;
      logic wr;
      logic scroll;
   } tcw_op_type;

   // result fields fixed at classification time
   typedef struct packed {
      logic        cell_written;
      logic [10:0] cell_index;
      logic [15:0] cell_value;
      logic        scrolled;
      logic [4:0]  cursor_row;
      logic [6:0]  cursor_column;
   } tcw_rsp_type;

   // back end status seen by the front end
   typedef struct packed {
      logic clearing;
   } tcw_stat_type;

   // back end sequencer
   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_RUN   = 3'b010,
      ST_FILL  = 3'b100
   } tcw_back_state_type;

endpackage

>>> hw/rtl/tcw_chan_if.sv
// request and response channel interfaces of the text console writer
// no dependencies
interface tcw_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [7:0]  char_byte;
   logic [10:0] read_index;

   modport source (output valid, action, char_byte, read_index, input ready);
   modport sink   (input valid, action, char_byte, read_index, output ready);
endinterface

interface tcw_rsp_if;
   logic        valid;
   logic        ready;
   logic        cell_written;
   logic [10:0] cell_index;
   logic [15:0] cell_value;
   logic        scrolled;
   logic [4:0]  cursor_row;
   logic [6:0]  cursor_column;
   logic [15:0] read_value;

   modport source (output valid, cell_written, cell_index, cell_value, scrolled,
                   cursor_row, cursor_column, read_value, input ready);
   modport sink   (input valid, cell_written, cell_index, cell_value, scrolled,
                   cursor_row, cursor_column, read_value, output ready);
endinterface

>>> hw/rtl/tcw_queue.sv
// small command fifo between console front end and back end
// depends on tcw_pkg for its depth
module tcw_queue import tcw_pkg::*; #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic              valid,
   output logic [DATA_W-1:0] pop_data
);

   logic [DATA_W-1:0] slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   // status and head entry
   assign full     = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign valid    = (count_ff != '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hw/rtl/tcw_front.sv
// console front end: takes request transfers, moves the cursor, emits commands
// depends on tcw_pkg for command and result types
module tcw_front import tcw_pkg::*; #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25,
   parameter int IDX_W   = $clog2(COLUMNS * ROWS)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_action,
   input  logic [7:0]       req_char_byte,
   input  logic [10:0]      req_read_index,
   input  logic [7:0]       text_attr,
   input  tcw_stat_type     stat,
   input  logic             q_full,
   output logic             q_push,
   output tcw_op_type       cmd_op,
   output tcw_rsp_type      cmd_rsp,
   output logic [IDX_W-1:0] cmd_addr
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int COL_W = $clog2(COLUMNS);
   localparam int ROW_W = $clog2(ROWS);
   localparam logic [COL_W-1:0] COL_LAST   = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0] ROW_LAST   = ROW_W'(ROWS - 1);
   localparam logic [IDX_W-1:0] ROW_STRIDE = IDX_W'(COLUMNS);

   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] row_start;
   logic             line_end;
   logic             rd_in_range;
   logic             accept;

   // take a transfer when the queue has room and the screen is cleared
   assign req_ready   = !q_full && !stat.clearing;
   assign accept      = req_valid && req_ready;
   assign q_push      = accept;
   assign rd_in_range = (32'(req_read_index) < 32'(CELLS));
   assign row_start   = idx_ff - IDX_W'(col_ff);

   // classify the item and work out the next cursor
   always_comb begin
      row_in   = row_ff;
      col_in   = col_ff;
      idx_in   = idx_ff;
      line_end = 1'b0;
      cmd_op   = '0;
      cmd_rsp  = '0;
      cmd_addr = idx_ff;
      if (req_action) begin
         cmd_op.rd = rd_in_range;
         cmd_addr  = IDX_W'(req_read_index);
      end else if (req_char_byte == CH_CR) begin
         col_in = '0;
         idx_in = row_start;
      end else if (req_char_byte == CH_LF) begin
         line_end = 1'b1;
      end else begin
         cmd_op.wr            = 1'b1;
         cmd_rsp.cell_written = 1'b1;
         cmd_rsp.cell_index   = 11'(idx_ff);
         cmd_rsp.cell_value   = {text_attr, req_char_byte};
         if (col_ff == COL_LAST) begin
            line_end = 1'b1;
         end else begin
            col_in = col_ff + COL_W'(1);
            idx_in = idx_ff + IDX_W'(1);
         end
      end
      // step to the next row, scrolling on the last one
      if (line_end) begin
         col_in = '0;
         if (row_ff == ROW_LAST) begin
            cmd_op.scroll    = 1'b1;
            cmd_rsp.scrolled = 1'b1;
            idx_in           = row_start;
         end else begin
            row_in = row_ff + ROW_W'(1);
            idx_in = row_start + ROW_STRIDE;
         end
      end
      cmd_rsp.cursor_row    = 5'(row_in);
      cmd_rsp.cursor_column = 7'(col_in);
   end

   // cursor registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
         idx_ff <= '0;
      end else if (accept) begin
         row_ff <= row_in;
         col_ff <= col_in;
         idx_ff <= idx_in;
      end
   end

endmodule

>>> hw/rtl/tcw_back.sv
// console back end: screen memory, row ring mapping, scroll fill, result register
// depends on tcw_pkg for command types and the sequencer states
module tcw_back import tcw_pkg::*; #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25,
   parameter int IDX_W   = $clog2(COLUMNS * ROWS)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  tcw_op_type       q_op,
   input  tcw_rsp_type      q_rsp,
   input  logic [IDX_W-1:0] q_addr,
   output logic             q_pop,
   input  logic [15:0]      blank_cell,
   output tcw_stat_type     stat,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tcw_rsp_type      rsp_fields,
   output logic [15:0]      rsp_read_value
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int COL_W = $clog2(COLUMNS);
   localparam logic [COL_W-1:0] COL_LAST   = COL_W'(COLUMNS - 1);
   localparam logic [IDX_W-1:0] CELL_LAST  = IDX_W'(CELLS - 1);
   localparam logic [IDX_W-1:0] ROW_STRIDE = IDX_W'(COLUMNS);
   localparam logic [IDX_W-1:0] BASE_LAST  = IDX_W'(CELLS - COLUMNS);
   localparam logic [IDX_W:0]   CELLS_EXT  = (IDX_W+1)'(CELLS);

   tcw_back_state_type state_ff, state_in;

   logic [15:0]      screen_ff [CELLS];
   logic [15:0]      mem_q_ff;
   logic [IDX_W-1:0] clr_ff;
   logic [COL_W-1:0] fill_ff;
   logic [IDX_W-1:0] base_ff;
   logic [15:0]      fill_val_ff;
   logic             out_vld_ff, out_vld_in;
   tcw_rsp_type      out_rsp_ff;
   logic             out_rd_ff;

   logic [IDX_W:0]   sum;
   logic [IDX_W-1:0] phys;
   logic             mem_we, mem_re;
   logic [IDX_W-1:0] mem_wa;
   logic [15:0]      mem_wd;

   // logical cell index to physical address through the row ring
   assign sum  = {1'b0, q_addr} + {1'b0, base_ff};
   assign phys = (sum >= CELLS_EXT) ? IDX_W'(sum - CELLS_EXT) : IDX_W'(sum);

   // pop when running and the result register is free or draining
   assign q_pop  = (state_ff == ST_RUN) && q_valid && (!out_vld_ff || rsp_ready);
   assign mem_re = q_pop && q_op.rd;
   assign stat.clearing = (state_ff == ST_CLEAR);

   // sequencer and memory write port select
   always_comb begin
      state_in = state_ff;
      mem_we   = 1'b0;
      mem_wa   = phys;
      mem_wd   = q_rsp.cell_value;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = RESET_BLANK;
            if (clr_ff == CELL_LAST) state_in = ST_RUN;
         end
         ST_RUN: begin
            mem_we = q_pop && q_op.wr;
            if (q_pop && q_op.scroll) state_in = ST_FILL;
         end
         ST_FILL: begin
            mem_we = 1'b1;
            mem_wa = base_ff + IDX_W'(fill_ff);
            mem_wd = fill_val_ff;
            if (fill_ff == COL_LAST) state_in = ST_RUN;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         fill_ff  <= '0;
         base_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + IDX_W'(1);
         end
         if (state_ff == ST_FILL) begin
            fill_ff <= (fill_ff == COL_LAST) ? '0 : fill_ff + COL_W'(1);
            // old top row becomes the new bottom row once filled
            if (fill_ff == COL_LAST) begin
               base_ff <= (base_ff == BASE_LAST) ? '0 : base_ff + ROW_STRIDE;
            end
         end
      end
   end

   // blank value held for the whole fill
   always_ff @(posedge clock) begin
      if (q_pop && q_op.scroll) begin
         fill_val_ff <= blank_cell;
      end
   end

   // screen memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_ff[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         mem_q_ff <= screen_ff[phys];
      end
   end

   // result register
   always_comb begin
      out_vld_in = out_vld_ff;
      if (q_pop) begin
         out_vld_in = 1'b1;
      end else if (rsp_ready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         out_rsp_ff <= q_rsp;
         out_rd_ff  <= q_op.rd;
      end
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_fields     = out_rsp_ff;
   assign rsp_read_value = out_rd_ff ? mem_q_ff : 16'h0000;

endmodule

>>> hw/rtl/text_console_writer_core.sv
// top level of the text console writer: registers, front end, queue, back end
// depends on tcw_pkg, tcw_chan_if, tcw_front, tcw_queue and tcw_back
//
// A COLUMNS x ROWS screen of 16-bit cells with a cursor.
// req_ch: each transfer puts one character (action 0) or reads one cell
//   (action 1, cell index row * COLUMNS + column; out of range reads zero).
// rsp_ch: exactly one result transfer per request, in request order,
//   with what was written, whether the screen scrolled, the new cursor
//   and the read value.
// csr_*: text attribute (index 0) and blank cell (index 1), written while idle.
// Path: a request passes through the command queue and the result register
//   before its result is valid on rsp_ch.
// Throughput: one item per cycle while the queue has room and no clear runs.
//   A scroll keeps the back end busy while the freed row is filled with
//   the blank cell; the four-entry command queue accepts meanwhile until full.
// Reset: the cursor goes home and the screen memory is cleared to 0x0720,
//   one cell a cycle, through all COLUMNS * ROWS cells;
//   req_ch.ready stays low until that is done.
// When rsp_ch stalls, the result register holds, the queue fills and
//   req_ch.ready drops once it is full.
module text_console_writer_core import tcw_pkg::*; #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                  clock,
   input  logic                  reset,
   tcw_req_if.sink               req_ch,
   tcw_rsp_if.source             rsp_ch,
   input  logic                  csr_write_en,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam int IDX_W  = $clog2(COLUMNS * ROWS);
   localparam int DATA_W = $bits(tcw_op_type) + $bits(tcw_rsp_type) + IDX_W;

   logic [7:0]        attr_ff;
   logic [15:0]       blank_ff;
   tcw_stat_type      stat;
   logic              q_full, q_push, q_pop, q_valid;
   tcw_op_type        cmd_op, q_op;
   tcw_rsp_type       cmd_rsp, q_rsp, out_rsp;
   logic [IDX_W-1:0]  cmd_addr, q_addr;
   logic [DATA_W-1:0] q_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff  <= RESET_ATTR;
         blank_ff <= RESET_BLANK;
      end else if (csr_write_en) begin
         unique case (tcw_csr_index_type'(csr_index))
            CSR_TEXT_ATTR:  attr_ff  <= csr_write_data[7:0];
            CSR_BLANK_CELL: blank_ff <= csr_write_data;
            default: begin
               attr_ff <= attr_ff;
            end
         endcase
      end
   end

   // front end
   tcw_front #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS),
      .IDX_W   (IDX_W)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_ch.valid),
      .req_ready      (req_ch.ready),
      .req_action     (req_ch.action),
      .req_char_byte  (req_ch.char_byte),
      .req_read_index (req_ch.read_index),
      .text_attr      (attr_ff),
      .stat           (stat),
      .q_full         (q_full),
      .q_push         (q_push),
      .cmd_op         (cmd_op),
      .cmd_rsp        (cmd_rsp),
      .cmd_addr       (cmd_addr)
   );

   // command queue
   tcw_queue #(
      .DATA_W (DATA_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({cmd_op, cmd_rsp, cmd_addr}),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_data  (q_data)
   );

   assign {q_op, q_rsp, q_addr} = q_data;

   // back end
   tcw_back #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS),
      .IDX_W   (IDX_W)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_op           (q_op),
      .q_rsp          (q_rsp),
      .q_addr         (q_addr),
      .q_pop          (q_pop),
      .blank_cell     (blank_ff),
      .stat           (stat),
      .rsp_valid      (rsp_ch.valid),
      .rsp_ready      (rsp_ch.ready),
      .rsp_fields     (out_rsp),
      .rsp_read_value (rsp_ch.read_value)
   );

   // result payload
   assign rsp_ch.cell_written  = out_rsp.cell_written;
   assign rsp_ch.cell_index    = out_rsp.cell_index;
   assign rsp_ch.cell_value    = out_rsp.cell_value;
   assign rsp_ch.scrolled      = out_rsp.scrolled;
   assign rsp_ch.cursor_row    = out_rsp.cursor_row;
   assign rsp_ch.cursor_column = out_rsp.cursor_column;

endmodule

>>> hw/rtl/tcw_checker.sv
// port-level checks of the text console writer, bound to its top level
// depends on tcw_pkg and text_console_writer_core_macros.svh
`include "text_console_writer_core_macros.svh"

module tcw_checker import tcw_pkg::*; #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_cell_written,
   input logic [10:0] rsp_cell_index,
   input logic [15:0] rsp_cell_value,
   input logic        rsp_scrolled,
   input logic [4:0]  rsp_cursor_row,
   input logic [6:0]  rsp_cursor_column,
   input logic [15:0] rsp_read_value
);

   localparam logic [4:0] ROW_LAST = 5'(ROWS - 1);

   // a stalled result stays and holds its payload
   `TCW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `TCW_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable({rsp_cell_written, rsp_cell_index, rsp_cell_value, rsp_scrolled, rsp_cursor_row, rsp_cursor_column, rsp_read_value}))

   // a stored cell never carries a control character and reads nothing
   `TCW_ASSERT_IMPLY(a_written_cell, clock, reset, rsp_valid && rsp_cell_written, rsp_read_value == 16'h0000 && rsp_cell_value[7:0] != CH_CR && rsp_cell_value[7:0] != CH_LF)

   // a scroll leaves the cursor at the start of the last row
   `TCW_ASSERT_IMPLY(a_scroll_cursor, clock, reset, rsp_valid && rsp_scrolled, rsp_cursor_row == ROW_LAST && rsp_cursor_column == 7'd0)

   // the cursor stays on the screen
   `TCW_ASSERT_IMPLY(a_cursor_range, clock, reset, rsp_valid, 32'(rsp_cursor_column) < 32'(COLUMNS) && 32'(rsp_cursor_row) < 32'(ROWS))

endmodule

bind text_console_writer_core tcw_checker #(
   .COLUMNS (COLUMNS),
   .ROWS    (ROWS)
) u_tcw_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_cell_written  (rsp_ch.cell_written),
   .rsp_cell_index    (rsp_ch.cell_index),
   .rsp_cell_value    (rsp_ch.cell_value),
   .rsp_scrolled      (rsp_ch.scrolled),
   .rsp_cursor_row    (rsp_ch.cursor_row),
   .rsp_cursor_column (rsp_ch.cursor_column),
   .rsp_read_value    (rsp_ch.read_value)
);

>>> dv/tcw_test_pkg.sv
// screen geometry, item actions and the result record used by the console testbench
// depends on tcw_pkg for the result field layout
package tcw_test_pkg;

   // screen geometry the block is built with
   localparam int SCREEN_COLUMNS = 80;
   localparam int SCREEN_ROWS    = 25;
   localparam int SCREEN_CELLS   = SCREEN_COLUMNS * SCREEN_ROWS;

   // what one request item asks for
   typedef enum logic {
      ACT_PUT  = 1'b0,
      ACT_READ = 1'b1
   } console_action_type;

   // one full result transfer
   typedef struct packed {
      tcw_pkg::tcw_rsp_type fields;
      logic [15:0]          read_value;
   } console_result_type;

endpackage

>>> dv/text_console_writer_core_checker.sv
// watches the console channels and register writes, tracks the screen and cursor,
// and compares every result transfer; depends on tcw_pkg, tcw_test_pkg, tcw_chan_if
module text_console_writer_core_checker
   import tcw_pkg::*;
   import tcw_test_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   tcw_req_if                    req_ch,
   tcw_rsp_if                    rsp_ch,
   input  logic                  csr_write_en,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   output int                    error_count,
   output int                    pending_results
);

   // tracked screen, cursor and register copies
   logic [15:0] screen [SCREEN_CELLS];
   int          cursor_row;
   int          cursor_col;
   logic [7:0]  attr_byte;
   logic [15:0] blank_value;
   int          mismatch_total = 0;

   // results still owed by the block, oldest first
   console_result_type awaited_results[$];

   // cursor to the next row; scroll the screen up when it runs off the bottom
   function automatic logic advance_row();
      cursor_col = 0;
      cursor_row++;
      if (cursor_row < SCREEN_ROWS)
         return 1'b0;
      for (int i = 0; i < SCREEN_CELLS - SCREEN_COLUMNS; i++)
         screen[i] = screen[i + SCREEN_COLUMNS];
      for (int i = SCREEN_CELLS - SCREEN_COLUMNS; i < SCREEN_CELLS; i++)
         screen[i] = blank_value;
      cursor_row = SCREEN_ROWS - 1;
      return 1'b1;
   endfunction

   // apply one request to the tracked screen and build the result it should give
   function automatic console_result_type console_apply(logic act, logic [7:0] ch,
                                                        logic [10:0] idx);
      console_result_type r;
      int                 at;
      r = '0;
      if (act == ACT_READ) begin
         if (idx < SCREEN_CELLS)
            r.read_value = screen[idx];
      end else if (ch == CH_CR) begin
         cursor_col = 0;
      end else if (ch == CH_LF) begin
         r.fields.scrolled = advance_row();
      end else begin
         // index is taken before any scroll this character causes
         at = cursor_row * SCREEN_COLUMNS + cursor_col;
         screen[at] = {attr_byte, ch};
         r.fields.cell_written = 1'b1;
         r.fields.cell_index   = at[10:0];
         r.fields.cell_value   = {attr_byte, ch};
         cursor_col++;
         if (cursor_col >= SCREEN_COLUMNS)
            r.fields.scrolled = advance_row();
      end
      r.fields.cursor_row    = cursor_row[4:0];
      r.fields.cursor_column = cursor_col[6:0];
      return r;
   endfunction

   task automatic compare_field(input string label, input logic [15:0] want,
                                input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h actual %h", $time, label, want, got);
         mismatch_total++;
      end
   endtask

   // sample register writes and both channels at each rising edge
   always @(posedge clock) begin : watch
      console_result_type due;
      if (reset) begin
         for (int i = 0; i < SCREEN_CELLS; i++)
            screen[i] = RESET_BLANK;
         cursor_row  = 0;
         cursor_col  = 0;
         attr_byte   = RESET_ATTR;
         blank_value = RESET_BLANK;
         awaited_results.delete();
      end else begin
         if (csr_write_en) begin
            case (tcw_csr_index_type'(csr_index))
               CSR_TEXT_ATTR:  attr_byte   = csr_write_data[7:0];
               CSR_BLANK_CELL: blank_value = csr_write_data[15:0];
               default:        ;
            endcase
         end
         // result transfer against the oldest expectation
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_results.size() == 0) begin
               $display("%0t: result transfer with none expected, actual %h", $time,
                        {rsp_ch.cell_written, rsp_ch.cell_index, rsp_ch.cell_value,
                         rsp_ch.scrolled, rsp_ch.cursor_row, rsp_ch.cursor_column,
                         rsp_ch.read_value});
               mismatch_total++;
            end else begin
               due = awaited_results.pop_front();
               compare_field("cell_written", 16'(due.fields.cell_written),
                             16'(rsp_ch.cell_written));
               compare_field("cell_index", 16'(due.fields.cell_index),
                             16'(rsp_ch.cell_index));
               compare_field("cell_value", due.fields.cell_value, rsp_ch.cell_value);
               compare_field("scrolled", 16'(due.fields.scrolled), 16'(rsp_ch.scrolled));
               compare_field("cursor_row", 16'(due.fields.cursor_row),
                             16'(rsp_ch.cursor_row));
               compare_field("cursor_column", 16'(due.fields.cursor_column),
                             16'(rsp_ch.cursor_column));
               compare_field("read_value", due.read_value, rsp_ch.read_value);
            end
         end
         // request transfer
         if (req_ch.valid && req_ch.ready)
            awaited_results.push_back(console_apply(req_ch.action, req_ch.char_byte,
                                                    req_ch.read_index));
      end
      pending_results <= awaited_results.size();
      error_count     <= mismatch_total;
   end

endmodule

>>> dv/text_console_writer_core_test.sv
// top of the console testbench: clock, reset, request stimulus, result stalls, verdict
// depends on tcw_pkg, tcw_test_pkg, tcw_chan_if, the checker and text_console_writer_core
module text_console_writer_core_test;
   import tcw_pkg::*;
   import tcw_test_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 2 * SCREEN_COLUMNS + 20;
   localparam int PHASE_ITEMS   = 87;
   localparam int HOLD_CYCLES   = 150;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_write_en;
   logic                  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;
   int                    error_count;
   int                    pending_results;
   int unsigned           cycle_count = 0;
   int unsigned           send_idle_pct = 0;
   int unsigned           recv_stall_pct = 0;
   bit                    hold_armed = 1'b0;
   bit                    hold_spent = 1'b0;

   tcw_req_if req_ch ();
   tcw_rsp_if rsp_ch ();

   text_console_writer_core #(
      .COLUMNS(SCREEN_COLUMNS),
      .ROWS   (SCREEN_ROWS)
   ) DUT (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_write_data(csr_write_data)
   );

   text_console_writer_core_checker console_check (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .error_count    (error_count),
      .pending_results(pending_results)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // result side: random stalls, plus one long hold-off
   initial begin : result_sink
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         if (hold_armed && !hold_spent) begin
            hold_spent = 1'b1;
            repeat (HOLD_CYCLES) begin
               rsp_ch.ready <= 1'b0;
               @(posedge clock);
            end
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            @(posedge clock);
         end
      end
   end

   // offer one request and hold it until the transfer
   task automatic send_item(input console_action_type act, input logic [7:0] ch,
                            input logic [10:0] idx);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.action     <= act;
      req_ch.char_byte  <= ch;
      req_ch.read_index <= idx;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
   endtask

   // mostly text with line breaks, reads biased toward the rows the cursor lives in
   task automatic send_random_item();
      int unsigned roll;
      int unsigned sel;
      roll = $urandom_range(99);
      sel  = $urandom_range(9);
      if (roll < 25) begin
         if (sel < 4)
            send_item(ACT_READ, 8'($urandom_range(255)), 11'($urandom_range(1999, 1520)));
         else if (sel < 8)
            send_item(ACT_READ, 8'($urandom_range(255)), 11'($urandom_range(1999)));
         else
            send_item(ACT_READ, 8'($urandom_range(255)), 11'($urandom_range(2047)));
      end else if (roll < 34) begin
         send_item(ACT_PUT, CH_LF, 11'($urandom_range(2047)));
      end else if (roll < 38) begin
         send_item(ACT_PUT, CH_CR, 11'($urandom_range(2047)));
      end else begin
         send_item(ACT_PUT, 8'($urandom_range(255)), 11'($urandom_range(2047)));
      end
   endtask

   // both registers back to back; the enable drops after the second
   task automatic load_settings(input logic [7:0] attr, input logic [15:0] blank);
      csr_write_en   <= 1'b1;
      csr_index      <= CSR_TEXT_ATTR;
      csr_write_data <= {8'h00, attr};
      @(posedge clock);
      csr_index      <= CSR_BLANK_CELL;
      csr_write_data <= blank;
      @(posedge clock);
      csr_write_en   <= 1'b0;
   endtask

   // stop offering, wait out every owed result, then let a scroll fill finish
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES)
         @(posedge clock);
   endtask

   initial begin : stimulus
      logic [7:0]  attr_set   [4];
      logic [15:0] blank_set  [4];
      int unsigned idle_set   [4];
      int unsigned stall_set  [4];
      attr_set  = '{8'h00, 8'hff, 8'($urandom_range(255)), RESET_ATTR};
      blank_set = '{16'h0000, 16'hffff, 16'($urandom_range(65535)), RESET_BLANK};
      idle_set  = '{0, 61, 0, 35};
      stall_set = '{0, 0, 61, 35};

      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.action     <= ACT_PUT;
      req_ch.char_byte  <= 8'h00;
      req_ch.read_index <= 11'd0;
      csr_write_en      <= 1'b0;
      csr_index         <= CSR_TEXT_ATTR;
      csr_write_data    <= '0;
      repeat (10)
         @(posedge clock);
      reset <= 1'b0;

      // directed: cleared screen, out-of-range reads, byte extremes, control characters
      send_item(ACT_READ, 8'h00, 11'd0);
      send_item(ACT_READ, 8'hff, 11'd1999);
      send_item(ACT_READ, 8'h00, 11'd2000);
      send_item(ACT_READ, CH_CR, 11'd2047);
      send_item(ACT_PUT, 8'h00, 11'd0);
      send_item(ACT_PUT, 8'hff, 11'd2047);
      send_item(ACT_PUT, 8'h7f, 11'd0);
      send_item(ACT_PUT, 8'h80, 11'd0);
      send_item(ACT_READ, CH_LF, 11'd0);
      send_item(ACT_READ, 8'h00, 11'd1);
      send_item(ACT_READ, 8'h00, 11'd3);
      send_item(ACT_PUT, CH_CR, 11'd0);
      send_item(ACT_PUT, 8'h41, 11'd0);
      send_item(ACT_READ, 8'h00, 11'd0);
      send_item(ACT_PUT, CH_LF, 11'd0);
      send_item(ACT_PUT, 8'h7a, 11'd0);
      send_item(ACT_PUT, CH_CR, 11'd0);
      send_item(ACT_PUT, CH_CR, 11'd0);
      send_item(ACT_READ, 8'h00, 11'd80);
      send_item(ACT_READ, 8'h00, 11'd1024);
      send_item(ACT_PUT, CH_LF, 11'd0);
      send_item(ACT_PUT, CH_LF, 11'd0);
      drain_results();

      // random phases, each with its own settings and idle pattern
      for (int p = 0; p < 4; p++) begin
         load_settings(attr_set[p], blank_set[p]);
         send_idle_pct  = idle_set[p];
         recv_stall_pct = stall_set[p];
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 0 && n == 10)
               hold_armed = 1'b1;
            // one unbroken line, long enough to wrap
            if (p == 2 && n == 20) begin
               for (int k = 0; k < SCREEN_COLUMNS + 5; k++)
                  send_item(ACT_PUT, 8'($urandom_range(126, 32)), 11'($urandom_range(2047)));
            end
            send_random_item();
         end
         drain_results();
      end

      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
